[rtl/bldc_phase_current_window_filter_unit_macros.svh]
// Assertion macros shared by the phase current window filter RTL.
`ifndef BLDC_PHASE_CURRENT_WINDOW_FILTER_UNIT_MACROS_SVH
`define BLDC_PHASE_CURRENT_WINDOW_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BPCWF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bpcwf: same-cycle check failed");
// next-cycle implication
`define BPCWF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bpcwf: next-cycle check failed");
`else
`define BPCWF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BPCWF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/bpcwf_pkg.sv]
// Types and constants of the phase current window filter.
`timescale 1ns / 1ps
`default_nettype none

package bpcwf_pkg;

	localparam int ADC_W    = 12;
	localparam int SAMPLE_W = 13;
	localparam int HALL_W   = 3;

	localparam int SHORT_WINDOW = 4;
	localparam int SHORT_SHIFT  = 2;

	localparam logic [ADC_W-1:0]           SAMPLE_CAP  = 12'd4095;
	localparam logic signed [SAMPLE_W-1:0] RUN_CAP     = 13'sd2000;
	localparam logic signed [SAMPLE_W:0]   SPIKE_LIMIT = 14'sd50;

	// register indexes (byte address bit 2)
	localparam logic REG_ZERO_BIAS   = 1'b0;
	localparam logic REG_WINDOW_MODE = 1'b1;

	typedef enum logic [1:0] {
		PH_U = 2'd0,
		PH_V = 2'd1,
		PH_W = 2'd2
	} phase_t;

	typedef struct packed {
		logic                       hall_bad;
		logic signed [SAMPLE_W-1:0] value;
	} samp_t;

	// conducting phase from hall code and direction
	function automatic phase_t pick_phase(input logic [HALL_W-1:0] hall, input logic rev);
		phase_t ph;
		ph = PH_U;
		unique case (hall)
			3'd1: ph = rev ? PH_V : PH_W;
			3'd2: ph = rev ? PH_U : PH_V;
			3'd3: ph = rev ? PH_U : PH_W;
			3'd4: ph = rev ? PH_W : PH_U;
			3'd5: ph = rev ? PH_V : PH_U;
			3'd6: ph = rev ? PH_W : PH_V;
			default: ph = PH_U;
		endcase
		return ph;
	endfunction

endpackage

`default_nettype wire

[rtl/bldc_phase_current_window_filter_unit.sv]
// Top level of the BLDC phase current window filter.
`timescale 1ns / 1ps
`default_nettype none
`include "bldc_phase_current_window_filter_unit_macros.svh"

// Moving-average filter for BLDC motor current. Each input beat carries three
// 12-bit phase ADC samples, the hall code, the direction and a run flag, and
// produces exactly one output beat. With window_mode = 1 (reset value) the
// conducting phase is picked from hall code and direction, zero_bias is
// subtracted, and once the eight-entry window is full any sample rising more
// than 50 above the last output is replaced by that output. Hall codes 0 and
// 7 repeat the last output with hall_invalid set and leave the filter state
// alone. With window_mode = 0 the absolute biased samples of all three phases
// are summed and halved and averaged over four entries. The sample is capped
// at 4095; the average is the running sum divided (rounding toward minus
// infinity) by the full window length, also while the window fills; while
// motor_running is set, positive results are capped at 2000. Writing a new
// window_mode restarts the fill; the last output is kept.
// Rate: one beat per clock, sustained while the output is not stalled. A beat
// is registered in stage 1 alongside the registered read of the sample ring
// RAM, then goes through the sum update into the output register. The ring
// slot read for a beat is never the one written by the beat ahead of it, so
// no forwarding is needed. A stalled output holds the pipeline; the input
// takes a beat whenever the second stage is empty or moving on.
// Registers (APB, 32-bit data): 0x0 zero_bias[11:0], 0x4 window_mode[0].
// Configure only while no beat is in flight.
module bldc_phase_current_window_filter_unit import bpcwf_pkg::*; #(
	parameter int RING_DEPTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// APB configuration
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [2:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output      logic [31:0]                prdata,
	output      logic                       pready,
	// input channel
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	input  wire logic [ADC_W-1:0]           adc_phase_u,
	input  wire logic [ADC_W-1:0]           adc_phase_v,
	input  wire logic [ADC_W-1:0]           adc_phase_w,
	input  wire logic [HALL_W-1:0]          hall_code,
	input  wire logic                       reverse_dir,
	input  wire logic                       motor_running,
	// output channel
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      logic signed [SAMPLE_W-1:0] filtered_current,
	output      logic                       hall_invalid
);

	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int FILL_W     = PTR_W + 1;
	localparam int RING_SHIFT = PTR_W;
	localparam int SUM_W      = $clog2(RING_DEPTH * int'(SAMPLE_CAP) + 1) + 1;
	localparam logic [FILL_W-1:0] LONG_WIN  = FILL_W'(RING_DEPTH);
	localparam logic [FILL_W-1:0] SHORT_WIN = FILL_W'(SHORT_WINDOW);
	localparam logic [PTR_W-1:0]  SHORT_MSK = PTR_W'(SHORT_WINDOW - 1);

	// configuration
	logic [ADC_W-1:0] bias_q;
	logic             mode_q;

	// front-end control
	logic [PTR_W-1:0]  wp_q;
	logic [FILL_W-1:0] fill_q;

	// stage 1
	logic                       s1_v_q;
	logic                       s1_bad_s1;
	logic                       s1_full_s1;
	logic                       s1_run_s1;
	logic [PTR_W-1:0]           s1_slot_s1;
	logic signed [SAMPLE_W-1:0] s1_samp_s1;

	// accumulator and output
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] last_q;
	logic                       out_v_q;
	logic signed [SAMPLE_W-1:0] out_cur_q;
	logic                       out_bad_q;

	samp_t                      samp;
	logic                       cfg_wr;
	logic                       accept;
	logic                       out_free;
	logic                       adv;
	logic [PTR_W-1:0]           slot0;
	logic [PTR_W-1:0]           wp_nx;
	logic [FILL_W-1:0]          win0;
	logic                       full0;
	logic [SAMPLE_W-1:0]        ring_rd;
	logic signed [SAMPLE_W:0]   spike_diff;
	logic signed [SAMPLE_W-1:0] new_samp;
	logic signed [SAMPLE_W-1:0] old_samp;
	logic signed [SUM_W-1:0]    sum_nx;
	logic signed [SUM_W-1:0]    avg_wide;
	logic signed [SAMPLE_W-1:0] avg;
	logic signed [SAMPLE_W-1:0] res;
	logic                       ring_we;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_ZERO_BIAS:   prdata = {{(32 - ADC_W){1'b0}}, bias_q};
			REG_WINDOW_MODE: prdata = {31'd0, mode_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			mode_q <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ZERO_BIAS) begin
				bias_q <= pwdata[ADC_W-1:0];
			end else begin
				mode_q <= pwdata[0];
			end
		end
	end

	// mode change restarts the window fill
	logic mode_chg;
	assign mode_chg = cfg_wr && (paddr[2] == REG_WINDOW_MODE) && (pwdata[0] != mode_q);

	// ---------------- stage 0: sample, slot, ring read ----------------
	bpcwf_sample u_sample (
		.adc_phase_u (adc_phase_u),
		.adc_phase_v (adc_phase_v),
		.adc_phase_w (adc_phase_w),
		.hall_code   (hall_code),
		.reverse_dir (reverse_dir),
		.zero_bias   (bias_q),
		.window_mode (mode_q),
		.samp        (samp)
	);

	assign out_free = !out_v_q || !out_stall;
	assign adv      = s1_v_q && out_free;
	assign in_stall = s1_v_q && !out_free;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		slot0 = mode_q ? wp_q : (wp_q & SHORT_MSK);
		wp_nx = mode_q ? (slot0 + 1'b1) : ((slot0 + 1'b1) & SHORT_MSK);
		win0  = mode_q ? LONG_WIN : SHORT_WIN;
		full0 = fill_q >= win0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (mode_chg) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (accept && !samp.hall_bad) begin
			wp_q <= wp_nx;
			if (!full0) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_bad_s1  <= samp.hall_bad;
			s1_full_s1 <= full0;
			s1_run_s1  <= motor_running;
			s1_slot_s1 <= slot0;
			s1_samp_s1 <= samp.value;
		end
	end

	// ---------------- sample ring ----------------
	assign ring_we = adv && !s1_bad_s1;

	bpcwf_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (s1_slot_s1),
		.wdata (new_samp),
		.re    (accept),
		.raddr (slot0),
		.rdata (ring_rd)
	);

	// ---------------- stage 1: spike reject, running sum, average ----------------
	always_comb begin
		spike_diff = $signed({s1_samp_s1[SAMPLE_W-1], s1_samp_s1})
			- $signed({last_q[SAMPLE_W-1], last_q});
		new_samp = (mode_q && s1_full_s1 && (spike_diff > SPIKE_LIMIT)) ? last_q : s1_samp_s1;
		old_samp = s1_full_s1 ? $signed(ring_rd) : '0;
		sum_nx   = sum_q
			- $signed({{(SUM_W - SAMPLE_W){old_samp[SAMPLE_W-1]}}, old_samp})
			+ $signed({{(SUM_W - SAMPLE_W){new_samp[SAMPLE_W-1]}}, new_samp});
		// arithmetic shift floors toward minus infinity
		avg_wide = mode_q ? (sum_nx >>> RING_SHIFT) : (sum_nx >>> SHORT_SHIFT);
		avg      = avg_wide[SAMPLE_W-1:0];
		res      = (s1_run_s1 && (avg > RUN_CAP)) ? RUN_CAP : avg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			last_q <= '0;
		end else if (mode_chg) begin
			sum_q <= '0;
		end else if (adv && !s1_bad_s1) begin
			sum_q  <= sum_nx;
			last_q <= res;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_cur_q <= s1_bad_s1 ? last_q : res;
			out_bad_q <= s1_bad_s1;
		end
	end

	assign out_valid        = out_v_q;
	assign filtered_current = out_cur_q;
	assign hall_invalid     = out_bad_q;

	// ---------------- checks ----------------
	`BPCWF_ASSERT_IMPLY(a_fill_bound, clk, arst_n, 1'b1, fill_q <= LONG_WIN)
	`BPCWF_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_v_q && !out_free, s1_v_q)
	`BPCWF_ASSERT_IMPLY(a_bad_repeats, clk, arst_n, out_v_q && out_bad_q, out_cur_q == last_q)
	`BPCWF_ASSERT_IMPLY(a_mode0_no_bad, clk, arst_n, s1_v_q && !mode_q, !s1_bad_s1)

endmodule

`default_nettype wire

[rtl/bpcwf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bpcwf_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/bpcwf_sample.sv]
// Sample builder: bias removal, phase pick or three-phase sum, capping.
`timescale 1ns / 1ps
`default_nettype none

module bpcwf_sample import bpcwf_pkg::*; (
	input  wire logic [ADC_W-1:0]  adc_phase_u,
	input  wire logic [ADC_W-1:0]  adc_phase_v,
	input  wire logic [ADC_W-1:0]  adc_phase_w,
	input  wire logic [HALL_W-1:0] hall_code,
	input  wire logic              reverse_dir,
	input  wire logic [ADC_W-1:0]  zero_bias,
	input  wire logic              window_mode,
	output      samp_t             samp
);

	logic signed [SAMPLE_W-1:0] du, dv, dw;
	logic [ADC_W-1:0]           au, av, aw;
	logic [ADC_W+1:0]           abs_sum;
	logic [SAMPLE_W-1:0]        half;
	logic [ADC_W-1:0]           half_cap;
	logic signed [SAMPLE_W-1:0] picked;

	always_comb begin
		du = $signed({1'b0, adc_phase_u}) - $signed({1'b0, zero_bias});
		dv = $signed({1'b0, adc_phase_v}) - $signed({1'b0, zero_bias});
		dw = $signed({1'b0, adc_phase_w}) - $signed({1'b0, zero_bias});

		// magnitudes stay within 12 bits
		au = du[SAMPLE_W-1] ? ADC_W'(-du) : du[ADC_W-1:0];
		av = dv[SAMPLE_W-1] ? ADC_W'(-dv) : dv[ADC_W-1:0];
		aw = dw[SAMPLE_W-1] ? ADC_W'(-dw) : dw[ADC_W-1:0];

		abs_sum  = {2'b00, au} + {2'b00, av} + {2'b00, aw};
		half     = abs_sum[ADC_W+1:1];
		half_cap = (half > {1'b0, SAMPLE_CAP}) ? SAMPLE_CAP : half[ADC_W-1:0];

		unique case (pick_phase(hall_code, reverse_dir))
			PH_U:    picked = du;
			PH_V:    picked = dv;
			PH_W:    picked = dw;
			default: picked = du;
		endcase

		// a biased single phase never exceeds the cap
		samp.value    = window_mode ? picked : $signed({1'b0, half_cap});
		samp.hall_bad = window_mode && (hall_code == 3'd0 || hall_code == 3'd7);
	end

endmodule

`default_nettype wire
